[rtl/dcad_pkg.sv]
package dcad_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PF_NONE   = 3'd0,
    PF_SAMPLE = 3'd1,
    PF_BUF    = 3'd2,
    PF_FLAGS  = 3'd3,
    PF_NEXT   = 3'd4
  } pend_t;

  localparam logic       SEL_DESC    = 1'b0;
  localparam logic [2:0] LEFT_CH     = 3'd1;
  localparam logic [2:0] RIGHT_CH    = 3'd2;
  localparam int         CTRL_START  = 4;
  localparam int         CTRL_LOAD   = 5;
  localparam logic [31:0] WORD_STEP  = 32'd4;
  localparam logic [31:0] FLAGS_OFS  = 32'd4;
  localparam logic [31:0] NEXT_OFS   = 32'd8;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  channel;
    logic        reg_select;
    logic [31:0] write_data;
    logic [31:0] read_data;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         out_channel;
    logic [31:0]        read_address;
    logic signed [15:0] sample;
    logic               last;
  } out_t;

  typedef struct packed {
    out_t        first;
    logic        has_second;
    logic [31:0] second_addr;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

[rtl/descriptor_chain_audio_dma_core.sv]
// Channel   | Signals                        | Moves
// ----------+--------------------------------+--------------------------------------
// input     | in_valid, in_ready, in_data    | host write, sample tick or read data
// result    | out_valid, out_ready, out_data | memory read request or DAC sample
//
// One request is taken per cycle while the result queue (4 entries) has room.
// The per-channel state is read and updated in the cycle a request is taken.
// A request with two results holds the result port until both are taken.
// A request with no result leaves no queue entry.
// Reset: synchronous; all channel state clears to zero.
module descriptor_chain_audio_dma_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dcad_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dcad_pkg::out_t out_data
);
  import dcad_pkg::*;

  logic     fire;
  logic     push;
  logic     pop;
  logic     full;
  q_entry_t push_entry;
  q_head_t  head;

  assign in_ready = !full;
  assign fire     = in_valid && in_ready;

  dcad_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (in_data),
    .push  (push),
    .entry (push_entry)
  );

  dcad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head       (head)
  );

  dcad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/dcad_front.sv]
module dcad_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dcad_pkg::in_t      req,
  output logic               push,
  output dcad_pkg::q_entry_t entry
);
  import dcad_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic        active_r [NUM_CHANNELS];
  logic [31:0] buf_r    [NUM_CHANNELS];
  logic [31:0] desc_r   [NUM_CHANNELS];
  logic        stop_r   [NUM_CHANNELS];
  logic [31:0] next_r   [NUM_CHANNELS];
  logic [31:0] rem_r    [NUM_CHANNELS];
  pend_t       pend_r   [NUM_CHANNELS];

  logic        active_nxt;
  logic [31:0] buf_nxt;
  logic [31:0] desc_nxt;
  logic        stop_nxt;
  logic [31:0] next_nxt;
  logic [31:0] rem_nxt;
  pend_t       pend_nxt;

  logic [CH_W-1:0] idx;
  logic            in_range;
  logic            dac_ch;
  logic            emit;
  logic [31:0]     rem_dec;
  logic [1:0]      smp_kind;

  assign in_range = ({1'b0, req.channel} < 4'(NUM_CHANNELS));
  assign idx      = req.channel[CH_W-1:0];
  assign dac_ch   = (req.channel == LEFT_CH) || (req.channel == RIGHT_CH);
  assign rem_dec  = rem_r[idx] - WORD_STEP;
  assign smp_kind = (req.channel == LEFT_CH) ? KIND_LEFT : KIND_RIGHT;

  always_comb begin
    active_nxt = active_r[idx];
    buf_nxt    = buf_r[idx];
    desc_nxt   = desc_r[idx];
    stop_nxt   = stop_r[idx];
    next_nxt   = next_r[idx];
    rem_nxt    = rem_r[idx];
    pend_nxt   = pend_r[idx];
    emit       = 1'b0;
    entry.first.kind         = KIND_REQ;
    entry.first.out_channel  = req.channel;
    entry.first.read_address = '0;
    entry.first.sample       = '0;
    entry.first.last         = 1'b1;
    entry.has_second         = 1'b0;
    entry.second_addr        = '0;
    case (op_t'(req.op))
      OP_WRITE: begin
        if (req.reg_select == SEL_DESC) begin
          if (pend_r[idx] == PF_NONE) begin
            desc_nxt = req.write_data;
            pend_nxt = PF_BUF;
            emit     = 1'b1;
            entry.first.read_address = req.write_data;
          end
        end else if (req.write_data[CTRL_START] && req.write_data[CTRL_LOAD] && dac_ch) begin
          active_nxt = 1'b1;
        end
      end
      OP_TICK: begin
        if (active_r[idx] && dac_ch && pend_r[idx] == PF_NONE) begin
          pend_nxt = PF_SAMPLE;
          emit     = 1'b1;
          entry.first.read_address = buf_r[idx];
        end
      end
      OP_READ: begin
        case (pend_r[idx])
          PF_BUF: begin
            buf_nxt  = req.read_data;
            pend_nxt = PF_FLAGS;
            emit     = 1'b1;
            entry.first.read_address = desc_r[idx] + FLAGS_OFS;
          end
          PF_FLAGS: begin
            stop_nxt = req.read_data[31];
            rem_nxt  = {1'b0, req.read_data[30:0]};
            pend_nxt = PF_NEXT;
            emit     = 1'b1;
            entry.first.read_address = desc_r[idx] + NEXT_OFS;
          end
          PF_NEXT: begin
            next_nxt = req.read_data;
            pend_nxt = PF_NONE;
          end
          PF_SAMPLE: begin
            pend_nxt = PF_NONE;
            buf_nxt  = buf_r[idx] + WORD_STEP;
            rem_nxt  = rem_dec;
            emit     = 1'b1;
            entry.first.kind   = smp_kind;
            entry.first.sample = {req.read_data[23:16], req.read_data[31:24]};
            if (rem_dec == '0) begin
              if (stop_r[idx]) begin
                active_nxt = 1'b0;
              end else begin
                desc_nxt          = next_r[idx];
                pend_nxt          = PF_BUF;
                entry.first.last  = 1'b0;
                entry.has_second  = 1'b1;
                entry.second_addr = next_r[idx];
              end
            end
          end
          default: begin
            pend_nxt = pend_r[idx];
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push = fire && in_range && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        active_r[i] <= 1'b0;
        buf_r[i]    <= '0;
        desc_r[i]   <= '0;
        stop_r[i]   <= 1'b0;
        next_r[i]   <= '0;
        rem_r[i]    <= '0;
        pend_r[i]   <= PF_NONE;
      end
    end else if (fire && in_range) begin
      active_r[idx] <= active_nxt;
      buf_r[idx]    <= buf_nxt;
      desc_r[idx]   <= desc_nxt;
      stop_r[idx]   <= stop_nxt;
      next_r[idx]   <= next_nxt;
      rem_r[idx]    <= rem_nxt;
      pend_r[idx]   <= pend_nxt;
    end
  end

endmodule

[rtl/dcad_queue.sv]
module dcad_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dcad_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output dcad_pkg::q_head_t  head
);
  import dcad_pkg::*;

  q_entry_t          q_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;
  logic [Q_AW:0]     count_nxt;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/dcad_back.sv]
module dcad_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dcad_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output dcad_pkg::out_t    out_data
);
  import dcad_pkg::*;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } phase_t;

  phase_t phase_r;
  phase_t phase_nxt;
  logic   take;

  assign out_valid = head.valid;
  assign take      = head.valid && out_ready;
  assign pop       = take && (phase_r == PH_SECOND || !head.entry.has_second);

  always_comb begin
    out_data = head.entry.first;
    if (phase_r == PH_SECOND) begin
      out_data.kind         = KIND_REQ;
      out_data.read_address = head.entry.second_addr;
      out_data.sample       = '0;
      out_data.last         = 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      case (phase_r)
        PH_FIRST:  phase_nxt = head.entry.has_second ? PH_SECOND : PH_FIRST;
        PH_SECOND: phase_nxt = PH_FIRST;
        default:   phase_nxt = PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule
